// ----- src/stt_pkg.sv -----
// package: payload types, cell data type and constants for step_toward_target
`timescale 1ns / 1ps
package stt_pkg;

	localparam int COORD_BITS = 16;
	localparam int SPEED_BITS = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_BITS = 16;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

	// vectoring word: |d| * 2^16, gain of about 1.65 and the y swing fit easily
	localparam int VW = COORD_BITS + FRAC_BITS + 3;
	// rebuild word: speed * (1/K) in Q8.16 stays below 2^24, gain K below 2^25
	localparam int UW = 27;
	// width of the coordinate sum before saturation
	localparam int SW = COORD_BITS + UW;
	// width of the arrival compare
	localparam int CW = COORD_BITS + FRAC_BITS + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] target_x;
		logic signed [COORD_BITS-1:0] target_y;
		logic        [SPEED_BITS-1:0] step_speed;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] new_x;
		logic signed [COORD_BITS-1:0] new_y;
		logic                         arrived;
	} res_t;

	typedef struct packed {
		logic                         valid;
		logic signed [VW-1:0]         x;
		logic signed [VW-1:0]         y;
		logic signed [UW-1:0]         u;
		logic signed [UW-1:0]         v;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] target_x;
		logic signed [COORD_BITS-1:0] target_y;
		logic        [COORD_BITS-1:0] abs_dx;
		logic        [COORD_BITS-1:0] abs_dy;
		logic                         flip;
		logic                         coincide;
	} cell_t;

endpackage

// ----- src/stt_cell.sv -----
// one cordic cell: vectoring micro-rotation and matching rebuild rotation
`timescale 1ns / 1ps
module stt_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stt_pkg::cell_t d,
	output stt_pkg::cell_t q
);
	import stt_pkg::*;

	cell_t nxt;
	logic  valid_q;
	cell_t data_q;

	always_comb begin
		nxt = d;
		// direction from the sign of y, shared by both rotations
		if (!d.y[VW-1]) begin
			nxt.x = d.x + (d.y >>> SHIFT);
			nxt.y = d.y - (d.x >>> SHIFT);
			nxt.u = d.u - (d.v >>> SHIFT);
			nxt.v = d.v + (d.u >>> SHIFT);
		end else begin
			nxt.x = d.x - (d.y >>> SHIFT);
			nxt.y = d.y + (d.x >>> SHIFT);
			nxt.u = d.u + (d.v >>> SHIFT);
			nxt.v = d.v - (d.u >>> SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		q       = data_q;
		q.valid = valid_q;
	end

endmodule

// ----- src/stt_finish.sv -----
// last cell: unflip, arrival test, floored step, saturation, result register
`timescale 1ns / 1ps
module stt_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::cell_t d,
	output logic           done,
	output stt_pkg::res_t  res
);
	import stt_pkg::*;

	logic signed [UW-1:0] su, sv;
	logic        [UW-1:0] mag_u, mag_v;
	logic        [CW-1:0] need_x, need_y, have_x, have_y;
	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;
	logic                 snap;
	res_t                 nxt;
	logic                 done_q;
	res_t                 res_q;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] s);
		logic ovf;
		ovf = (s[SW-1:COORD_BITS-1] != {(SW-COORD_BITS+1){1'b0}})
			&& (s[SW-1:COORD_BITS-1] != {(SW-COORD_BITS+1){1'b1}});
		if (ovf) begin
			sat_coord = s[SW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			sat_coord = s[COORD_BITS-1:0];
		end
	endfunction

	always_comb begin
		su = d.flip ? -d.u : d.u;
		sv = d.flip ? -d.v : d.v;
		// magnitude is the same before and after the unflip
		mag_u = d.u[UW-1] ? UW'(-d.u) : UW'(d.u);
		mag_v = d.v[UW-1] ? UW'(-d.v) : UW'(d.v);
		need_x = CW'({d.abs_dx, {FRAC_BITS{1'b0}}});
		need_y = CW'({d.abs_dy, {FRAC_BITS{1'b0}}});
		have_x = CW'(mag_u);
		have_y = CW'(mag_v);
		snap = d.coincide || ((need_x <= have_x) && (need_y <= have_y));
		// floor of Q8.16 to whole pixels is one arithmetic shift
		sum_x = SW'(d.pos_x) + SW'(su >>> FRAC_BITS);
		sum_y = SW'(d.pos_y) + SW'(sv >>> FRAC_BITS);
		sat_x = sat_coord(sum_x);
		sat_y = sat_coord(sum_y);
		if (snap) begin
			nxt.new_x   = d.target_x;
			nxt.new_y   = d.target_y;
			nxt.arrived = 1'b1;
		end else begin
			nxt.new_x   = sat_x;
			nxt.new_y   = sat_y;
			nxt.arrived = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= nxt;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- src/step_toward_target.sv -----
// top level: entry register, row of cordic cells, finishing cell
`timescale 1ns / 1ps
// a start beat passes the entry register, each cordic cell and the finish register
// throughput: one beat per cycle, set by the fully pipelined row of cells
// busy stays low; results leave on a one-cycle done strobe, no stall path
// reset: arst_n clears every valid flag at once; payload registers are not reset
// a beat in flight during reset is dropped and gives no result
module step_toward_target #(
	parameter int CORDIC_STAGES = stt_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stt_pkg::cmd_t cmd,
	output logic          done,
	output stt_pkg::res_t res
);
	import stt_pkg::*;

	// difference vector, one bit wider than a coordinate
	logic signed [COORD_BITS:0]   dx, dy, fdx, fdy;
	logic                         flip;
	// 16x16 product for speed times the inverse cordic gain
	logic        [31:0]           prod;
	cell_t                        entry;
	logic                         entry_valid_q;
	cell_t                        entry_data_s1;
	// data handed from cell to cell
	cell_t                        chain [CORDIC_STAGES+1];

	// the pipeline never holds off a beat
	assign busy = 1'b0;

	always_comb begin
		dx   = (COORD_BITS+1)'(cmd.target_x) - (COORD_BITS+1)'(cmd.pos_x);
		dy   = (COORD_BITS+1)'(cmd.target_y) - (COORD_BITS+1)'(cmd.pos_y);
		flip = dx[COORD_BITS];
		// left half plane: mirror through the origin before vectoring
		fdx  = flip ? -dx : dx;
		fdy  = flip ? -dy : dy;
		prod = cmd.step_speed * INV_GAIN_Q16;

		entry.valid    = start;
		entry.x        = VW'(fdx) <<< FRAC_BITS;
		entry.y        = VW'(fdy) <<< FRAC_BITS;
		// initial step (speed / K, 0) in Q8.16
		entry.u        = UW'(prod[31:8]);
		entry.v        = '0;
		entry.pos_x    = cmd.pos_x;
		entry.pos_y    = cmd.pos_y;
		entry.target_x = cmd.target_x;
		entry.target_y = cmd.target_y;
		entry.abs_dx   = fdx[COORD_BITS-1:0];
		entry.abs_dy   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		entry.flip     = flip;
		// coincident points snap straight onto the target
		entry.coincide = (dx == '0) && (dy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else begin
			entry_valid_q <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		entry_data_s1 <= entry;
	end

	always_comb begin
		chain[0]       = entry_data_s1;
		chain[0].valid = entry_valid_q;
	end

	// one cell per micro-rotation, cell i shifts by i
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		stt_cell #(
			.SHIFT(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end

	stt_finish u_finish (
		.clk   (clk),
		.arst_n(arst_n),
		.d     (chain[CORDIC_STAGES]),
		.done  (done),
		.res   (res)
	);

endmodule

// ----- src/stt_checker.sv -----
// checker on the top level ports, bound to step_toward_target
`timescale 1ns / 1ps
module stt_checker #(
	parameter int LAT = stt_pkg::CORDIC_STAGES_DEF + 2
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input stt_pkg::cmd_t cmd,
	input logic          done,
	input stt_pkg::res_t res
);
	import stt_pkg::*;

	// every accepted beat gives a result after the fixed latency
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat gave no result");

	// no result without a beat accepted the latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a beat");

	// an arrival puts the point exactly on its target
	a_snap_target: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.arrived) |->
			(res.new_x == $past(cmd.target_x, LAT)) && (res.new_y == $past(cmd.target_y, LAT)))
		else $error("arrival off target");

	// coincident points always report arrival
	a_coincide: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.pos_x == cmd.target_x && cmd.pos_y == cmd.target_y, LAT))
			|-> res.arrived)
		else $error("coincident points not arrived");

endmodule

bind step_toward_target stt_checker #(.LAT(CORDIC_STAGES + 2)) u_stt_checker (.*);
